// ----- src/salru_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// salru_pkg - shared types and constants for the LRU write-back tag store
// Access and result payloads, config register indexes, controller states.
// ============================================================================
package salru_pkg;

    // Default geometry
    localparam int MAX_SET_BITS_DEF = 6;
    localparam int WAYS_DEF         = 8;
    localparam int ADDR_BITS_DEF    = 64;

    // Block offset clamp and fixed counter widths
    localparam int MAX_BLOCK_BITS = 16;
    localparam int DIRTY_CNT_W    = 10;
    localparam int WAY_CNT_W      = 5;   // holds ways_in_use (4 bits) and WAYS up to 16
    localparam int CFG_DATA_W     = 5;
    localparam int CFG_IDX_W      = 2;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_SET_BITS    = 2'd0;
    localparam cfg_idx_t CFG_WAYS_IN_USE = 2'd1;
    localparam cfg_idx_t CFG_BLOCK_BITS  = 2'd2;

    typedef struct packed {
        logic        action;
        logic [63:0] address;
    } access_t;

    typedef struct packed {
        logic        hit;
        logic        evicted;
        logic        dirty_evicted;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] eviction_total;
        logic [25:0] dirty_held_bytes;
        logic [47:0] dirty_evicted_bytes;
    } result_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

endpackage

// ----- src/set_assoc_cache_lru_dirty.sv -----
`timescale 1ns / 1ps
// ============================================================================
// set_assoc_cache_lru_dirty - write-back set-associative tag store, true LRU
// Looks up each access in one set row, counts hits, misses and evictions,
// tracks dirty lines and reports running totals.
// ============================================================================
//
// Usage:
//   Access channel: drive access (action, address) with start; the transfer
//   happens at a rising edge where start is high and busy is low.
//   Result channel: done pulses for one cycle with result valid beside it,
//   both registered at the end of the lookup state. There is no back-pressure; the
//   receiver must take the result in that cycle.
//   Sequencing: at the transfer the set row is read from the tag memory (one
//   synchronous read port); the lookup state then does the tag compare,
//   victim pick and LRU update and writes the row back; busy is high in the
//   lookup state, so an access never meets a row write in flight.
//   Config: wr_en/wr_index/wr_data write set_bits, ways_in_use, block_bits
//   (index 0, 1, 2) at the edge; other indexes are dropped. Write only idle.
//   Reset: counters clear at once, config returns to 4/8/4, then a clearing
//   pass writes every set row (2**MAX_SET_BITS, 64 by default) to zero with
//   busy high. Config writes are taken during that pass.
//
module set_assoc_cache_lru_dirty #(
    parameter int MAX_SET_BITS = salru_pkg::MAX_SET_BITS_DEF,
    parameter int WAYS         = salru_pkg::WAYS_DEF,
    parameter int ADDR_BITS    = salru_pkg::ADDR_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  salru_pkg::access_t                  access,
    output logic                                done,
    output salru_pkg::result_t                  result,
    input  logic                                wr_en,
    input  salru_pkg::cfg_idx_t                 wr_index,
    input  logic [salru_pkg::CFG_DATA_W-1:0]    wr_data
);
    import salru_pkg::*;

    localparam int NUM_SETS  = 1 << MAX_SET_BITS;
    localparam int SET_IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int AGE_W     = WAY_W;
    localparam int SHIFT_W   = 6;   // block (<=16) plus set (<=7) offset
    localparam logic [AGE_W-1:0]     AGE_MAX   = AGE_W'(WAYS - 1);
    localparam logic [3:0]           S_MAX     = 4'(MAX_SET_BITS);
    localparam logic [WAY_CNT_W-1:0] N_MAX     = WAY_CNT_W'(WAYS);
    localparam logic [4:0]           B_MAX     = 5'(MAX_BLOCK_BITS);
    localparam logic [SET_IDX_W-1:0] LAST_SET  = SET_IDX_W'(NUM_SETS - 1);

    typedef struct packed {
        logic                 valid;
        logic                 dirty;
        logic [AGE_W-1:0]     age;
        logic [ADDR_BITS-1:0] tag;
    } line_t;

    typedef line_t [WAYS-1:0] row_t;

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic [2:0] set_bits_reg;
    logic [3:0] ways_reg;
    logic [4:0] block_bits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= 3'd4;
            ways_reg       <= 4'd8;
            block_bits_reg <= 5'd4;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_SET_BITS:    set_bits_reg   <= wr_data[2:0];
                CFG_WAYS_IN_USE: ways_reg       <= wr_data[3:0];
                CFG_BLOCK_BITS:  block_bits_reg <= wr_data;
                default:         ;   // no register at this index
            endcase
        end
    end

    // Clamped config
    logic [3:0]           s_eff;
    logic [4:0]           b_eff;
    logic [WAY_CNT_W-1:0] n_eff;

    always_comb
    begin
        s_eff = ({1'b0, set_bits_reg} > S_MAX) ? S_MAX : {1'b0, set_bits_reg};
        b_eff = (block_bits_reg > B_MAX) ? B_MAX : block_bits_reg;
        if (ways_reg == 4'd0)
            n_eff = WAY_CNT_W'(1);
        else if (WAY_CNT_W'(ways_reg) > N_MAX)
            n_eff = N_MAX;
        else
            n_eff = WAY_CNT_W'(ways_reg);
    end

    // ------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------
    state_t state_reg, state_next;
    logic [SET_IDX_W-1:0] clr_cnt_reg, clr_cnt_next;

    logic accept;
    logic lookup_en;
    logic mem_we;
    logic [SET_IDX_W-1:0] mem_waddr;
    row_t mem_wdata;

    assign accept = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:  if (clr_cnt_reg == LAST_SET) state_next = ST_IDLE;
            ST_IDLE:   if (start) state_next = ST_LOOKUP;
            ST_LOOKUP: state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    row_t new_row;
    logic [SET_IDX_W-1:0] set_reg;

    always_comb
    begin
        busy         = 1'b1;
        lookup_en    = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = set_reg;
        mem_wdata    = new_row;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_LOOKUP:
            begin
                lookup_en = 1'b1;
                mem_we    = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Address split at transfer time
    // ------------------------------------------------------------------
    logic [ADDR_BITS-1:0] addr_m;
    logic [ADDR_BITS-1:0] set_field;
    logic [SET_IDX_W-1:0] set_in;
    logic [ADDR_BITS-1:0] tag_in;
    logic [SHIFT_W-1:0]   tag_shift;

    always_comb
    begin
        addr_m    = access.address[ADDR_BITS-1:0];
        set_field = (addr_m >> b_eff) & ~({ADDR_BITS{1'b1}} << s_eff);
        set_in    = set_field[SET_IDX_W-1:0];
        tag_shift = SHIFT_W'(b_eff) + SHIFT_W'(s_eff);
        tag_in    = addr_m >> tag_shift;
    end

    logic                 store_reg;
    logic [ADDR_BITS-1:0] tag_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            store_reg <= access.action;
            set_reg   <= set_in;
            tag_reg   <= tag_in;
        end
    end

    // ------------------------------------------------------------------
    // Tag memory: one row per set, sync read, one write port
    // ------------------------------------------------------------------
    row_t tag_mem [NUM_SETS];
    row_t rd_row_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            tag_mem[mem_waddr] <= mem_wdata;
        if (accept)
            rd_row_reg <= tag_mem[set_in];
    end

    // ------------------------------------------------------------------
    // Lookup, victim select and LRU update on the read row
    // ------------------------------------------------------------------
    logic [WAYS-1:0]  used;
    logic [WAYS-1:0]  match;
    logic [WAYS-1:0]  free;
    logic             hit_any;
    logic             free_any;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] free_way;
    logic [WAY_W-1:0] vic_way;
    logic [AGE_W-1:0] best_age;
    logic [WAY_W-1:0] way_sel;
    logic [AGE_W-1:0] age_lim;
    logic             evict;
    logic             dirty_evict;
    logic             dirty_inc;

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            used[w]  = WAY_CNT_W'(w) < n_eff;
            match[w] = used[w] && rd_row_reg[w].valid && (rd_row_reg[w].tag == tag_reg);
            free[w]  = used[w] && !rd_row_reg[w].valid;
        end
        hit_any  = |match;
        free_any = |free;

        // lowest-numbered match / free way
        hit_way  = '0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
                hit_way = WAY_W'(w);
            if (free[w])
                free_way = WAY_W'(w);
        end

        // oldest in-use way, ties to the lowest number
        vic_way  = '0;
        best_age = rd_row_reg[0].age;
        for (int w = 1; w < WAYS; w++)
        begin
            if (used[w] && rd_row_reg[w].age > best_age)
            begin
                best_age = rd_row_reg[w].age;
                vic_way  = WAY_W'(w);
            end
        end

        if (hit_any)
            way_sel = hit_way;
        else if (free_any)
            way_sel = free_way;
        else
            way_sel = vic_way;

        evict       = !hit_any && !free_any;
        dirty_evict = evict && rd_row_reg[way_sel].dirty;
        dirty_inc   = store_reg && (!hit_any || !rd_row_reg[way_sel].dirty);
        age_lim     = rd_row_reg[hit_way].age;

        // hit: age valid lines younger than the touched one; miss: age all other valid lines
        new_row = rd_row_reg;
        for (int w = 0; w < WAYS; w++)
        begin
            if (used[w] && (WAY_W'(w) != way_sel) && rd_row_reg[w].valid
                && (!hit_any || rd_row_reg[w].age < age_lim)
                && (rd_row_reg[w].age < AGE_MAX))
                new_row[w].age = rd_row_reg[w].age + 1'b1;
        end
        new_row[way_sel].age = '0;
        if (hit_any)
        begin
            new_row[way_sel].dirty = rd_row_reg[way_sel].dirty | store_reg;
        end
        else
        begin
            new_row[way_sel].valid = 1'b1;
            new_row[way_sel].dirty = store_reg;
            new_row[way_sel].tag   = tag_reg;
        end
    end

    // ------------------------------------------------------------------
    // Running totals and result register
    // ------------------------------------------------------------------
    logic [31:0]            hits_reg, hits_next;
    logic [31:0]            misses_reg, misses_next;
    logic [31:0]            evicts_reg, evicts_next;
    logic [31:0]            dirty_evicts_reg, dirty_evicts_next;
    logic [DIRTY_CNT_W-1:0] dirty_lines_reg, dirty_lines_next;
    logic                   done_reg;
    result_t                result_reg, result_next;

    always_comb
    begin
        hits_next         = hits_reg + 32'(hit_any);
        misses_next       = misses_reg + 32'(!hit_any);
        evicts_next       = evicts_reg + 32'(evict);
        dirty_evicts_next = dirty_evicts_reg + 32'(dirty_evict);
        dirty_lines_next  = dirty_lines_reg - DIRTY_CNT_W'(dirty_evict)
                            + DIRTY_CNT_W'(dirty_inc);

        result_next.hit                 = hit_any;
        result_next.evicted             = evict;
        result_next.dirty_evicted       = dirty_evict;
        result_next.hit_total           = hits_next;
        result_next.miss_total          = misses_next;
        result_next.eviction_total      = evicts_next;
        result_next.dirty_held_bytes    = 26'(dirty_lines_next) << b_eff;
        result_next.dirty_evicted_bytes = 48'(dirty_evicts_next) << b_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_reg         <= '0;
            misses_reg       <= '0;
            evicts_reg       <= '0;
            dirty_evicts_reg <= '0;
            dirty_lines_reg  <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            done_reg <= lookup_en;
            if (lookup_en)
            begin
                hits_reg         <= hits_next;
                misses_reg       <= misses_next;
                evicts_reg       <= evicts_next;
                dirty_evicts_reg <= dirty_evicts_next;
                dirty_lines_reg  <= dirty_lines_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (lookup_en)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // every transfer yields its result strobe at the end of its lookup
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("result strobe missing two cycles after transfer");

    // a result only ever follows a lookup cycle
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_LOOKUP))
        else $error("result strobe without a lookup");

    // hit excludes eviction; a dirty eviction is an eviction
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!(result.hit && result.evicted)
                  && (!result.dirty_evicted || result.evicted)))
        else $error("inconsistent result flags");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb - self-checking bench for the LRU write-back cache tag store
// Drives load/store accesses through the start/busy command port and checks
// every done strobe against a cycle-free model of the tag store: true LRU
// with saturating ages, write-back dirty tracking and wrapping totals. A short
// table of directed accesses and register writes comes first, then random
// phases, each with its own geometry and sender idling.
// ============================================================================
module tb;

    import salru_pkg::*;

    localparam int NUM_SETS    = 1 << MAX_SET_BITS_DEF;
    localparam int NUM_WAYS    = WAYS_DEF;
    localparam int NUM_PHASES  = 10;
    localparam int PHASE_ITEMS = 80;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_STORE = 1'b1;

    // Outcome of one access as {hit, evicted, dirty_evicted}
    localparam logic [2:0] OUT_MISS        = 3'b000;
    localparam logic [2:0] OUT_HIT         = 3'b100;
    localparam logic [2:0] OUT_EVICT       = 3'b010;
    localparam logic [2:0] OUT_DIRTY_EVICT = 3'b011;

    // Index with no register behind it; the block drops writes to it
    localparam cfg_idx_t CFG_UNUSED = 2'd3;

    typedef enum bit {ROW_ACCESS, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic        action;
        logic [63:0] address;
        cfg_idx_t    index;
        logic [4:0]  data;
        bit          typed;
        logic [2:0]  outcome;
    } plan_row_t;

    // One access in flight: the model's result plus an optional typed outcome
    typedef struct {
        result_t    lookup;
        bit         typed;
        logic [2:0] outcome;
    } pending_t;

    typedef struct packed {
        logic [2:0] set_bits;
        logic [3:0] ways;
        logic [4:0] block_bits;
        logic [6:0] idle_pct;
    } phase_t;

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    access_t  access = '0;
    logic     done;
    result_t  result;
    logic     wr_en = 1'b0;
    cfg_idx_t wr_index = '0;
    logic [CFG_DATA_W-1:0] wr_data = '0;

    set_assoc_cache_lru_dirty u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .access   (access),
        .done     (done),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Tag store model: its own line arrays, totals and register copies.
    // Lines reset invalid/clean; tags and ages are only read on valid lines.
    // ------------------------------------------------------------------------
    bit          way_valid [NUM_SETS][NUM_WAYS];
    bit          way_dirty [NUM_SETS][NUM_WAYS];
    logic [63:0] way_tag   [NUM_SETS][NUM_WAYS];
    logic [2:0]  way_age   [NUM_SETS][NUM_WAYS];

    logic [31:0] hit_count     = '0;
    logic [31:0] miss_count    = '0;
    logic [31:0] evict_count   = '0;
    logic [31:0] dirty_evicts  = '0;
    logic [9:0]  dirty_lines   = '0;

    logic [2:0]  cfg_set_bits   = 3'd4;
    logic [3:0]  cfg_ways       = 4'd8;
    logic [4:0]  cfg_block_bits = 5'd4;

    pending_t    predicted_lookups [$];
    plan_row_t   directed_rows [$];
    logic [63:0] tag_pool [16];

    // Driver -> monitor side info for the access now on the port
    bit          row_typed = 1'b0;
    logic [2:0]  row_outcome = OUT_MISS;
    int unsigned idle_pct = 0;

    int unsigned fail_count   = 0;
    int unsigned results_seen = 0;
    int unsigned cycle_count  = 0;

    // Effective register values after clamping
    function automatic int unsigned eff_set_bits();
        return (cfg_set_bits > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : cfg_set_bits;
    endfunction

    function automatic int unsigned eff_block_bits();
        return (cfg_block_bits > MAX_BLOCK_BITS) ? MAX_BLOCK_BITS : cfg_block_bits;
    endfunction

    function automatic int unsigned eff_ways();
        if (cfg_ways == 0)
            return 1;
        return (cfg_ways > NUM_WAYS) ? NUM_WAYS : cfg_ways;
    endfunction

    // Age valid in-use lines younger than limit, skipping the touched way.
    // Ages stop at NUM_WAYS-1.
    function automatic void age_others(int unsigned set_idx, int unsigned n,
                                       int unsigned skip, int unsigned limit);
        for (int unsigned w = 0; w < n; w++)
        begin
            if (w != skip && way_valid[set_idx][w] && way_age[set_idx][w] < limit &&
                way_age[set_idx][w] < NUM_WAYS - 1)
                way_age[set_idx][w] = way_age[set_idx][w] + 3'd1;
        end
    endfunction

    // One access through the model: lookup, LRU update, fill/evict, totals.
    function automatic result_t predict_lookup(access_t acc);
        int unsigned s, b, n, set_idx, way, best;
        logic [63:0] tag, wide;
        bit          is_hit, found, ev, dev, is_store;
        result_t     r;
        s        = eff_set_bits();
        b        = eff_block_bits();
        n        = eff_ways();
        is_store = (acc.action == ACT_STORE);
        set_idx  = int'((acc.address >> b) & ((64'd1 << s) - 64'd1));
        tag      = acc.address >> (b + s);
        is_hit   = 1'b0;
        found    = 1'b0;
        ev       = 1'b0;
        dev      = 1'b0;
        way      = 0;

        for (int unsigned w = 0; w < n; w++)
        begin
            if (!is_hit && way_valid[set_idx][w] && way_tag[set_idx][w] == tag)
            begin
                is_hit = 1'b1;
                way    = w;
            end
        end

        if (is_hit)
        begin
            hit_count = hit_count + 32'd1;
            // true LRU: only lines younger than the touched one move
            age_others(set_idx, n, way, way_age[set_idx][way]);
            way_age[set_idx][way] = '0;
            if (is_store && !way_dirty[set_idx][way])
            begin
                way_dirty[set_idx][way] = 1'b1;
                dirty_lines = dirty_lines + 10'd1;
            end
        end
        else
        begin
            miss_count = miss_count + 32'd1;
            // lowest empty way first
            for (int unsigned w = 0; w < n; w++)
            begin
                if (!found && !way_valid[set_idx][w])
                begin
                    found = 1'b1;
                    way   = w;
                end
            end
            if (!found)
            begin
                // oldest way; ties go to the lowest way number
                best = 0;
                for (int unsigned w = 0; w < n; w++)
                begin
                    if (w == 0 || way_age[set_idx][w] > best)
                    begin
                        best = way_age[set_idx][w];
                        way  = w;
                    end
                end
                ev = 1'b1;
                evict_count = evict_count + 32'd1;
                if (way_dirty[set_idx][way])
                begin
                    dev = 1'b1;
                    dirty_evicts = dirty_evicts + 32'd1;
                    dirty_lines = dirty_lines - 10'd1;
                end
            end
            age_others(set_idx, n, way, NUM_WAYS + 1);
            way_valid[set_idx][way] = 1'b1;
            way_tag[set_idx][way]   = tag;
            way_age[set_idx][way]   = '0;
            way_dirty[set_idx][way] = is_store;
            if (is_store)
                dirty_lines = dirty_lines + 10'd1;
        end

        r.hit            = is_hit;
        r.evicted        = ev;
        r.dirty_evicted  = dev;
        r.hit_total      = hit_count;
        r.miss_total     = miss_count;
        r.eviction_total = evict_count;
        wide             = '0;
        wide[9:0]        = dirty_lines;
        wide             = wide << b;
        r.dirty_held_bytes = wide[25:0];
        wide             = '0;
        wide[31:0]       = dirty_evicts;
        wide             = wide << b;
        r.dirty_evicted_bytes = wide[47:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (act_v !== exp_v)
            report_failure($sformatf("result %0d %s: expected 0x%0h, got 0x%0h",
                                     results_seen, name, exp_v, act_v));
    endtask

    task automatic check_lookup(pending_t e, result_t got);
        check_field("hit", e.lookup.hit, got.hit);
        check_field("evicted", e.lookup.evicted, got.evicted);
        check_field("dirty_evicted", e.lookup.dirty_evicted, got.dirty_evicted);
        check_field("hit_total", e.lookup.hit_total, got.hit_total);
        check_field("miss_total", e.lookup.miss_total, got.miss_total);
        check_field("eviction_total", e.lookup.eviction_total, got.eviction_total);
        check_field("dirty_held_bytes", e.lookup.dirty_held_bytes, got.dirty_held_bytes);
        check_field("dirty_evicted_bytes", e.lookup.dirty_evicted_bytes,
                    got.dirty_evicted_bytes);
        // directed rows also carry an outcome typed in by hand
        if (e.typed)
            check_field("outcome", e.outcome, {got.hit, got.evicted, got.dirty_evicted});
    endtask

    // Monitor: everything sampled at the rising edge. Register writes are
    // mirrored, each access transfer is run through the model, and each done
    // strobe is matched against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (wr_en)
            begin
                case (wr_index)
                    CFG_SET_BITS:    cfg_set_bits   = wr_data[2:0];
                    CFG_WAYS_IN_USE: cfg_ways       = wr_data[3:0];
                    CFG_BLOCK_BITS:  cfg_block_bits = wr_data;
                    default:         ;
                endcase
            end
            if (start && !busy)
                predicted_lookups.push_back('{predict_lookup(access), row_typed, row_outcome});
            if (done)
            begin
                if (predicted_lookups.size() == 0)
                    report_failure($sformatf("result %0d with no access pending",
                                             results_seen));
                else
                    check_lookup(predicted_lookups.pop_front(), result);
                results_seen++;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** set_assoc_cache_lru_dirty: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers. Inputs change at the falling edge only.
    // ------------------------------------------------------------------------

    // Present one access and hold it until the transfer (start && !busy at a
    // rising edge). start stays high across back-to-back transfers; a gap
    // lowers it for whole cycles only.
    task automatic send_access(logic act, logic [63:0] addr, bit typed, logic [2:0] outcome);
        if (idle_pct != 0)
        begin
            while ($urandom_range(99) < idle_pct)
            begin
                start = 1'b0;
                @(negedge clk);
            end
        end
        start          = 1'b1;
        access.action  = act;
        access.address = addr;
        row_typed      = typed;
        row_outcome    = outcome;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Every access yields one result, so an empty queue means the block is idle
    task automatic wait_drained();
        start = 1'b0;
        while (predicted_lookups.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [4:0] data);
        wr_en    = 1'b1;
        wr_index = idx;
        wr_data  = data;
        @(negedge clk);
        wr_en    = 1'b0;
    endtask

    task automatic plan_access(logic act, logic [63:0] addr, bit typed, logic [2:0] outcome);
        plan_row_t row;
        row.kind    = ROW_ACCESS;
        row.action  = act;
        row.address = addr;
        row.index   = CFG_SET_BITS;
        row.data    = '0;
        row.typed   = typed;
        row.outcome = outcome;
        directed_rows.push_back(row);
    endtask

    task automatic plan_write(cfg_idx_t idx, logic [4:0] data);
        plan_row_t row;
        row.kind    = ROW_WRITE;
        row.action  = ACT_LOAD;
        row.address = '0;
        row.index   = idx;
        row.data    = data;
        row.typed   = 1'b0;
        row.outcome = OUT_MISS;
        directed_rows.push_back(row);
    endtask

    // Random address for the current geometry. Mostly tags from a small pool
    // into a few sets, so lines get reused, aged and evicted; the rest is
    // raw 64-bit noise and corner patterns.
    function automatic logic [63:0] pick_address();
        int unsigned s, b, n, nsets, mode, set_idx;
        logic [63:0] tag, set_w, off;
        s     = eff_set_bits();
        b     = eff_block_bits();
        n     = eff_ways();
        nsets = 1 << s;
        mode  = $urandom_range(99);
        if (mode < 75)
        begin
            tag = tag_pool[$urandom_range(n + 3)];
            if ($urandom_range(3) == 0)
                set_idx = $urandom_range(nsets - 1);
            else
                set_idx = $urandom_range((nsets > 4) ? 3 : nsets - 1);
            set_w = 64'(set_idx);
            off   = {$urandom, $urandom} & ((64'd1 << b) - 64'd1);
            return (tag << (b + s)) | (set_w << b) | off;
        end
        if (mode < 90)
            return {$urandom, $urandom};
        case ($urandom_range(3))
            0:       return '1;
            1:       return '0;
            2:       return 64'h8000_0000_0000_0000;
            default: return ~(64'd1 << $urandom_range(63));
        endcase
    endfunction

    // Geometry and sender idling per random phase: extremes of every
    // register, out-of-range values that clamp, and stretches with no gaps.
    function automatic phase_t phase_plan(int unsigned p);
        case (p)
            0:       return {3'd4, 4'd8,  5'd4,  7'd0};
            1:       return {3'd0, 4'd1,  5'd0,  7'd78};
            2:       return {3'd6, 4'd8,  5'd16, 7'd27};
            3:       return {3'd2, 4'd3,  5'd5,  7'd0};
            4:       return {3'd7, 4'd15, 5'd31, 7'd78};
            5:       return {3'd1, 4'd0,  5'd17, 7'd27};
            6:       return {3'd3, 4'd4,  5'd2,  7'd0};
            7:       return {3'd5, 4'd9,  5'd12, 7'd78};
            8:       return {3'd2, 4'd8,  5'd0,  7'd27};
            default: return {3'd0, 4'd8,  5'd16, 7'd0};
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        plan_row_t row;
        phase_t    ph;

        // Reset once; the clearing pass that follows holds busy high
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        while (busy)
            @(negedge clk);

        // Directed table, reset geometry first (16 sets, 8 ways, 16-byte blocks)
        plan_access(ACT_LOAD,  64'h0, 1'b1, OUT_MISS);      // cold miss, fills way 0
        plan_access(ACT_LOAD,  64'h8, 1'b1, OUT_HIT);       // same block
        plan_access(ACT_STORE, 64'hF, 1'b1, OUT_HIT);       // hit marks the line dirty
        plan_access(ACT_LOAD,  '1,    1'b1, OUT_MISS);      // top set, all-ones tag
        plan_access(ACT_STORE, '1,    1'b1, OUT_HIT);
        plan_write(CFG_WAYS_IN_USE, 5'd0);                  // zero ways acts as one
        plan_access(ACT_LOAD,  64'h100, 1'b1, OUT_DIRTY_EVICT);
        plan_access(ACT_STORE, 64'h200, 1'b1, OUT_EVICT);   // victim was a clean load
        plan_write(CFG_WAYS_IN_USE, 5'd15);                 // clamps to all ways
        plan_access(ACT_LOAD,  64'h100, 1'b1, OUT_MISS);    // way 1 still empty
        plan_write(CFG_SET_BITS, 5'd7);                     // clamps to max set bits
        plan_write(CFG_BLOCK_BITS, 5'd31);                  // clamps to 64 KB blocks
        plan_access(ACT_STORE, 64'h8000_0000_0000_0000, 1'b0, OUT_MISS);
        plan_access(ACT_LOAD,  64'h7FFF_FFFF_FFFF_FFFF, 1'b0, OUT_MISS);
        plan_write(CFG_UNUSED, 5'd31);                      // must be dropped
        plan_write(CFG_SET_BITS, 5'd0);                     // one set, byte blocks
        plan_write(CFG_BLOCK_BITS, 5'd0);
        plan_write(CFG_WAYS_IN_USE, 5'd8);
        // nine stores into the single set: fill, then evict dirty LRU lines
        for (int unsigned k = 1; k <= 9; k++)
            plan_access(ACT_STORE, 64'(k), 1'b0, OUT_MISS);
        plan_access(ACT_LOAD, 64'd2, 1'b0, OUT_MISS);
        plan_access(ACT_LOAD, 64'd1, 1'b0, OUT_MISS);

        while (directed_rows.size() != 0)
        begin
            row = directed_rows.pop_front();
            if (row.kind == ROW_WRITE)
            begin
                wait_drained();
                write_reg(row.index, row.data);
            end
            else
                send_access(row.action, row.address, row.typed, row.outcome);
        end

        // Random phases; lines survive each reconfiguration on purpose
        for (int unsigned p = 0; p < NUM_PHASES; p++)
        begin
            ph = phase_plan(p);
            wait_drained();
            write_reg(CFG_SET_BITS, {2'b00, ph.set_bits});
            write_reg(CFG_WAYS_IN_USE, {1'b0, ph.ways});
            write_reg(CFG_BLOCK_BITS, ph.block_bits);
            idle_pct = ph.idle_pct;
            for (int unsigned i = 0; i < 16; i++)
                tag_pool[i] = (i < 10) ? 64'(i) : {$urandom, $urandom};
            for (int unsigned i = 0; i < PHASE_ITEMS; i++)
                send_access($urandom_range(1), pick_address(), 1'b0, OUT_MISS);
        end

        // Drain, then wait for any stray strobe
        wait_drained();
        repeat (8) @(negedge clk);
        if (fail_count == 0 && predicted_lookups.size() == 0)
            $display("** set_assoc_cache_lru_dirty: PASSED **");
        else
            $display("** set_assoc_cache_lru_dirty: FAILED **");
        $finish;
    end

endmodule
